// File: hw/rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and helper functions for the clock set and chime
// controller.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam logic [3:0] DigitBlank  = 4'd10;
  localparam logic [7:0] ShortMin    = 8'd10;
  localparam logic [7:0] ShortMax    = 8'd15;
  localparam logic [5:0] ReleaseLoad = 6'd50;
  localparam logic [4:0] HourNoon    = 5'd12;
  localparam logic [4:0] HourLast    = 5'd23;
  localparam logic [5:0] MinuteLast  = 6'd59;
  localparam logic [4:0] BrightReset = 5'd15;

  typedef enum logic [2:0] {
    CFG_CHIME_FIRST  = 3'd0,
    CFG_CHIME_LAST   = 3'd1,
    CFG_LONG_PRESS   = 3'd2,
    CFG_SET_TIMEOUT  = 3'd3,
    CFG_HOUR_REPEAT  = 3'd4,
    CFG_MINUTE_REPEAT = 3'd5,
    CFG_BRIGHT_MAX   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STEP_CAPTURE = 2'd0,
    STEP_HOUR    = 2'd1,
    STEP_MINUTE  = 2'd2,
    STEP_WRITE   = 2'd3
  } edit_step_t;

  typedef enum logic [1:0] {
    GRP_HOUR   = 2'd0,
    GRP_MINUTE = 2'd1,
    GRP_ALL    = 2'd2
  } blink_grp_t;

  typedef struct packed {
    logic [4:0] chime_first;
    logic [4:0] chime_last;
    logic [7:0] long_press;
    logic [9:0] set_timeout;
    logic [7:0] hour_repeat;
    logic [7:0] minute_repeat;
    logic [4:0] bright_max;
  } cfg_t;

  typedef struct packed {
    logic       key_mode;
    logic       key_up;
    logic       key_down;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tick_t;

  // request from the control engine to the display formatter
  typedef struct packed {
    logic       upd;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       blank_lead;
  } disp_req_t;

  typedef struct packed {
    logic       chime;
    logic       blink_on;
    logic [1:0] blink_group;
    logic [4:0] brightness;
    logic       write_time;
    logic [4:0] write_hour;
    logic [5:0] write_minute;
    logic [5:0] write_second;
  } ctl_res_t;

  // saturating increment of a hold counter
  function automatic logic [7:0] bump8(input logic [7:0] c);
    return (c == 8'hFF) ? 8'hFF : c + 8'd1;
  endfunction

  // split a value of 0..63 into {tens, ones}
  function automatic logic [7:0] dec_split(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] base;
    if (v >= 6'd60)      tens = 4'd6;
    else if (v >= 6'd50) tens = 4'd5;
    else if (v >= 6'd40) tens = 4'd4;
    else if (v >= 6'd30) tens = 4'd3;
    else if (v >= 6'd20) tens = 4'd2;
    else if (v >= 6'd10) tens = 4'd1;
    else                 tens = 4'd0;
    base = 6'(6'(tens) * 6'd10);
    return {tens, 4'(v - base)};
  endfunction

endpackage

// File: hw/rtl/ccc_display.sv
// ----------------------------------------------------------------------------
// ccc_display
// Digit formatter: splits hour and minute into four decimal digits, blanks a
// leading hour zero on request and holds the shown digits between updates.
// ----------------------------------------------------------------------------
module ccc_display
  import ccc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  disp_req_t  req,
  output logic [3:0] digits_nxt [4]
);

  logic [3:0] digits_r [4];
  logic [7:0] hour_split;
  logic [7:0] min_split;

  assign hour_split = dec_split({1'b0, req.hour});
  assign min_split  = dec_split(req.minute);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      digits_nxt[i] = digits_r[i];
    end
    if (req.upd) begin
      digits_nxt[0] = (req.blank_lead && hour_split[7:4] == 4'd0) ? DigitBlank
                                                                   : hour_split[7:4];
      digits_nxt[1] = hour_split[3:0];
      digits_nxt[2] = min_split[7:4];
      digits_nxt[3] = min_split[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        digits_r[i] <= DigitBlank;
      end
    end else if (en) begin
      for (int i = 0; i < 4; i++) begin
        digits_r[i] <= digits_nxt[i];
      end
    end
  end

endmodule

// File: hw/rtl/ccc_engine.sv
// ----------------------------------------------------------------------------
// ccc_engine
// Per-tick control: key hold counting, short and long press, chime, brightness
// auto-repeat, set mode sequencing with hour and minute edit and idle timeout.
// ----------------------------------------------------------------------------
module ccc_engine
  import ccc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  cfg_t      cfg,
  input  tick_t     tick,
  output disp_req_t disp_req,
  output ctl_res_t  res
);

  logic       set_r, set_nxt;
  edit_step_t step_r, step_nxt;
  logic [7:0] mhc_r, mhc_nxt;
  logic       spp_r, spp_nxt;
  logic [5:0] rw_r, rw_nxt;
  logic       flag_r, flag_nxt;
  logic [7:0] uhc_r, uhc_nxt;
  logic [7:0] dhc_r, dhc_nxt;
  logic [9:0] idle_r, idle_nxt;
  logic [4:0] eh_r, eh_nxt;
  logic [5:0] em_r, em_nxt;
  logic [5:0] es_r, es_nxt;
  logic [4:0] bl_r, bl_nxt;
  logic       chime_r, chime_nxt;
  logic       blink_on_r, blink_on_nxt;
  blink_grp_t grp_r, grp_nxt;

  logic [7:0] mhc_b, uhc_b, dhc_b;
  logic [4:0] bmax;
  logic [5:0] bl_tmp;
  logic [4:0] hour12;
  logic [9:0] idle_dec;
  logic       wr;

  assign mhc_b = bump8(mhc_r);
  assign uhc_b = bump8(uhc_r);
  assign dhc_b = bump8(dhc_r);
  assign bmax  = (cfg.bright_max == 5'd0) ? 5'd1 : cfg.bright_max;
  assign idle_dec = (idle_r == 10'd0) ? 10'd0 : idle_r - 10'd1;

  always_comb begin
    set_nxt      = set_r;
    step_nxt     = step_r;
    mhc_nxt      = mhc_r;
    spp_nxt      = spp_r;
    rw_nxt       = rw_r;
    flag_nxt     = flag_r;
    uhc_nxt      = uhc_r;
    dhc_nxt      = dhc_r;
    idle_nxt     = idle_r;
    eh_nxt       = eh_r;
    em_nxt       = em_r;
    es_nxt       = es_r;
    bl_nxt       = bl_r;
    chime_nxt    = chime_r;
    blink_on_nxt = blink_on_r;
    grp_nxt      = grp_r;
    wr           = 1'b0;
    bl_tmp       = {1'b0, bl_r};
    hour12       = tick.hour;
    disp_req     = '{upd: 1'b0, hour: eh_r, minute: em_r, blank_lead: 1'b1};

    if (!set_r) begin
      blink_on_nxt = 1'b0;
      if (cfg.chime_first <= tick.hour && tick.hour <= cfg.chime_last) begin
        chime_nxt = (tick.minute == 6'd0) && (tick.second[5:2] == 4'd0) && !tick.second[0];
      end

      if (tick.key_mode) begin
        mhc_nxt = mhc_b;
        if (mhc_b > ShortMin && mhc_b < ShortMax) begin
          spp_nxt = 1'b1;
          rw_nxt  = ReleaseLoad;
        end
        if (mhc_b > cfg.long_press) begin
          set_nxt  = 1'b1;
          idle_nxt = cfg.set_timeout;
          mhc_nxt  = 8'd0;
        end
      end else if (spp_r && rw_r != 6'd0) begin
        flag_nxt = ~flag_r;
        spp_nxt  = 1'b0;
        mhc_nxt  = 8'd0;
      end else if (rw_r != 6'd0) begin
        rw_nxt = rw_r - 6'd1;
      end

      hour12   = (flag_nxt && tick.hour > HourNoon) ? tick.hour - HourNoon : tick.hour;
      disp_req = '{upd: 1'b1, hour: hour12, minute: tick.minute, blank_lead: 1'b1};

      if (tick.key_up) begin
        uhc_nxt = uhc_b;
        if (uhc_b > cfg.hour_repeat) begin
          bl_tmp  = bl_tmp + 6'd1;
          bl_tmp  = (bl_tmp > {1'b0, bmax}) ? {1'b0, bmax} : bl_tmp;
          uhc_nxt = 8'd0;
        end
      end
      if (tick.key_down) begin
        dhc_nxt = dhc_b;
        if (dhc_b > cfg.hour_repeat) begin
          bl_tmp  = (bl_tmp <= 6'd1) ? 6'd1 : bl_tmp - 6'd1;
          bl_tmp  = (bl_tmp > {1'b0, bmax}) ? {1'b0, bmax} : bl_tmp;
          dhc_nxt = 8'd0;
        end
      end
      bl_nxt = bl_tmp[4:0];
    end else begin
      if (tick.key_mode) begin
        mhc_nxt = mhc_b;
        if (mhc_b > cfg.long_press) begin
          step_nxt = edit_step_t'(step_r + 2'd1);
          idle_nxt = cfg.set_timeout;
          mhc_nxt  = 8'd0;
        end
      end else begin
        idle_nxt = idle_dec;
        if (idle_dec == 10'd0) begin
          set_nxt  = 1'b0;
          step_nxt = STEP_CAPTURE;
        end
      end

      unique case (step_nxt)
        STEP_HOUR: begin
          blink_on_nxt = 1'b1;
          grp_nxt      = GRP_HOUR;
          disp_req     = '{upd: 1'b1, hour: eh_r, minute: em_r, blank_lead: 1'b1};
          if (tick.key_up) begin
            uhc_nxt = uhc_b;
            if (uhc_b > cfg.hour_repeat) begin
              eh_nxt   = (eh_nxt >= HourLast) ? 5'd0 : eh_nxt + 5'd1;
              idle_nxt = cfg.set_timeout;
              uhc_nxt  = 8'd0;
            end
          end
          if (tick.key_down) begin
            dhc_nxt = dhc_b;
            if (dhc_b > cfg.hour_repeat) begin
              eh_nxt   = (eh_nxt == 5'd0) ? HourLast : eh_nxt - 5'd1;
              idle_nxt = cfg.set_timeout;
              dhc_nxt  = 8'd0;
            end
          end
        end
        STEP_MINUTE: begin
          blink_on_nxt = 1'b1;
          grp_nxt      = GRP_MINUTE;
          disp_req     = '{upd: 1'b1, hour: eh_r, minute: em_r, blank_lead: 1'b0};
          if (tick.key_up) begin
            uhc_nxt = uhc_b;
            if (uhc_b > cfg.minute_repeat) begin
              em_nxt   = (em_nxt >= MinuteLast) ? 6'd0 : em_nxt + 6'd1;
              idle_nxt = cfg.set_timeout;
              uhc_nxt  = 8'd0;
            end
          end
          if (tick.key_down) begin
            dhc_nxt = dhc_b;
            if (dhc_b > cfg.minute_repeat) begin
              em_nxt   = (em_nxt == 6'd0) ? MinuteLast : em_nxt - 6'd1;
              idle_nxt = cfg.set_timeout;
              dhc_nxt  = 8'd0;
            end
          end
        end
        STEP_WRITE: begin
          wr       = 1'b1;
          step_nxt = STEP_CAPTURE;
          set_nxt  = 1'b0;
        end
        STEP_CAPTURE: begin
          blink_on_nxt = 1'b1;
          grp_nxt      = GRP_ALL;
          eh_nxt       = tick.hour;
          em_nxt       = tick.minute;
          es_nxt       = tick.second;
        end
      endcase
    end
  end

  always_comb begin
    res.chime        = chime_nxt;
    res.blink_on     = blink_on_nxt;
    res.blink_group  = grp_nxt;
    res.brightness   = bl_nxt;
    res.write_time   = wr;
    res.write_hour   = wr ? eh_nxt : 5'd0;
    res.write_minute = wr ? em_nxt : 6'd0;
    res.write_second = wr ? es_nxt : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r      <= 1'b0;
      step_r     <= STEP_CAPTURE;
      mhc_r      <= 8'd0;
      spp_r      <= 1'b0;
      rw_r       <= 6'd0;
      flag_r     <= 1'b0;
      uhc_r      <= 8'd0;
      dhc_r      <= 8'd0;
      idle_r     <= 10'd0;
      eh_r       <= 5'd0;
      em_r       <= 6'd0;
      es_r       <= 6'd0;
      bl_r       <= BrightReset;
      chime_r    <= 1'b0;
      blink_on_r <= 1'b0;
      grp_r      <= GRP_HOUR;
    end else if (en) begin
      set_r      <= set_nxt;
      step_r     <= step_nxt;
      mhc_r      <= mhc_nxt;
      spp_r      <= spp_nxt;
      rw_r       <= rw_nxt;
      flag_r     <= flag_nxt;
      uhc_r      <= uhc_nxt;
      dhc_r      <= dhc_nxt;
      idle_r     <= idle_nxt;
      eh_r       <= eh_nxt;
      em_r       <= em_nxt;
      es_r       <= es_nxt;
      bl_r       <= bl_nxt;
      chime_r    <= chime_nxt;
      blink_on_r <= blink_on_nxt;
      grp_r      <= grp_nxt;
    end
  end

endmodule

// File: hw/rtl/clock_set_and_chime_controller.sv
// ----------------------------------------------------------------------------
// clock_set_and_chime_controller
// Top level: configuration registers, input register, control engine, digit
// formatter and result register.
// ----------------------------------------------------------------------------
// One transaction on the input channel is one 20 ms tick; it yields exactly
// one result transaction. The block takes a tick every clock cycle while
// out_ready stays high: a tick is held in the input register, the control
// engine and digit formatter evaluate it in a single pass, and the result
// register loads the outcome when the result slot is empty or being taken.
// While a result waits for out_ready the input register still takes one
// more tick; in_ready then drops until the waiting result leaves. The
// configuration port is always ready; write it only while no tick is in
// flight. Indexes beyond the register list are ignored.
module clock_set_and_chime_controller
  import ccc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_key_mode,
  input  logic       in_key_up,
  input  logic       in_key_down,
  input  logic [4:0] in_now_hour,
  input  logic [5:0] in_now_minute,
  input  logic [5:0] in_now_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_chime_level,
  output logic [3:0] out_digit_one,
  output logic [3:0] out_digit_two,
  output logic [3:0] out_digit_three,
  output logic [3:0] out_digit_four,
  output logic       out_blink_on,
  output logic [1:0] out_blink_group,
  output logic [4:0] out_brightness,
  output logic       out_write_time,
  output logic [4:0] out_write_hour,
  output logic [5:0] out_write_minute,
  output logic [5:0] out_write_second
);

  cfg_t       cfg_r;
  tick_t      tick_r;
  logic       in_vld_r;
  logic       out_vld_r;
  logic       adv;
  disp_req_t  disp_req;
  ctl_res_t   res;
  logic [3:0] digits_nxt [4];
  ctl_res_t   res_r;
  logic [3:0] digits_r [4];

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{chime_first: 5'd6, chime_last: 5'd22, long_press: 8'd50,
                 set_timeout: 10'd800, hour_repeat: 8'd10, minute_repeat: 8'd15,
                 bright_max: 5'd30};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHIME_FIRST:   cfg_r.chime_first   <= cfg_data[4:0];
        CFG_CHIME_LAST:    cfg_r.chime_last    <= cfg_data[4:0];
        CFG_LONG_PRESS:    cfg_r.long_press    <= cfg_data[7:0];
        CFG_SET_TIMEOUT:   cfg_r.set_timeout   <= cfg_data;
        CFG_HOUR_REPEAT:   cfg_r.hour_repeat   <= cfg_data[7:0];
        CFG_MINUTE_REPEAT: cfg_r.minute_repeat <= cfg_data[7:0];
        CFG_BRIGHT_MAX:    cfg_r.bright_max    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_r <= '{key_mode: in_key_mode, key_up: in_key_up, key_down: in_key_down,
                  hour: in_now_hour, minute: in_now_minute, second: in_now_second};
    end
  end

  ccc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cfg      (cfg_r),
    .tick     (tick_r),
    .disp_req (disp_req),
    .res      (res)
  );

  ccc_display u_display (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .req        (disp_req),
    .digits_nxt (digits_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
      for (int i = 0; i < 4; i++) begin
        digits_r[i] <= digits_nxt[i];
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_chime_level  = res_r.chime;
  assign out_digit_one    = digits_r[0];
  assign out_digit_two    = digits_r[1];
  assign out_digit_three  = digits_r[2];
  assign out_digit_four   = digits_r[3];
  assign out_blink_on     = res_r.blink_on;
  assign out_blink_group  = res_r.blink_group;
  assign out_brightness   = res_r.brightness;
  assign out_write_time   = res_r.write_time;
  assign out_write_hour   = res_r.write_hour;
  assign out_write_minute = res_r.write_minute;
  assign out_write_second = res_r.write_second;

endmodule

// File: hw/rtl/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks for the clock set and chime controller, bound to the top.
// ----------------------------------------------------------------------------
module ccc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_chime_level,
  input logic [3:0] out_digit_one,
  input logic [3:0] out_digit_two,
  input logic [3:0] out_digit_three,
  input logic [3:0] out_digit_four,
  input logic       out_blink_on,
  input logic [1:0] out_blink_group,
  input logic [4:0] out_brightness,
  input logic       out_write_time,
  input logic [4:0] out_write_hour,
  input logic [5:0] out_write_minute,
  input logic [5:0] out_write_second
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_brightness)
      && $stable(out_write_time) && $stable(out_digit_two)
      && $stable(out_chime_level) && $stable(out_digit_one)
      && $stable(out_digit_three) && $stable(out_digit_four)
      && $stable(out_blink_on) && $stable(out_blink_group)
      && $stable(out_write_hour) && $stable(out_write_minute)
      && $stable(out_write_second))
    else $error("result changed while stalled");

  // the write fields carry data only on a write transaction
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_time |-> out_write_hour == 5'd0
      && out_write_minute == 6'd0 && out_write_second == 6'd0)
    else $error("write fields nonzero without write_time");

  // brightness never drops below the lower clamp
  a_bright_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_brightness != 5'd0)
    else $error("brightness zero");

  // digit codes stay in their decimal ranges
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_one <= 4'd10 && out_digit_two <= 4'd9
      && out_digit_three <= 4'd9 && out_digit_four <= 4'd9)
    else $error("digit code out of range");

endmodule

bind clock_set_and_chime_controller ccc_checker u_ccc_checker (.*);
